FILE: hdl/i2c_eeprom_byte_access_master_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared assertion forms for the EEPROM master core; clocked on clk_i and
// disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef I2C_EEPROM_BYTE_ACCESS_MASTER_CORE_ASSERT_SVH
`define I2C_EEPROM_BYTE_ACCESS_MASTER_CORE_ASSERT_SVH

// property must hold at every edge out of reset
`define I2CEBM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition must never be seen out of reset
`define I2CEBM_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

FILE: hdl/i2cebm_pkg.sv
// ----------------------------------------------------------------------------
// i2cebm_pkg
// Types and constants of the I2C EEPROM byte access master.
// ----------------------------------------------------------------------------
package i2cebm_pkg;

  // input word
  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] mem_address;
    logic [7:0]  write_data;
    logic        sda_in;
  } in_item_t;

  // result word
  typedef struct packed {
    logic       scl_level;
    logic       sda_release;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       retry;
  } out_item_t;

  // input kind codes
  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  // classified word kind
  typedef enum logic [1:0] {
    CMD_TICK,
    CMD_WRITE,
    CMD_READ
  } cmd_e;

  // queue entry
  typedef struct packed {
    cmd_e        cmd;
    logic [15:0] mem_address;
    logic [7:0]  write_data;
    logic        sda_in;
  } q_item_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_DEV_ADDR    = 2'd0,
    REG_HALF_PERIOD = 2'd1,
    REG_ACK_TIMEOUT = 2'd2,
    REG_WRITE_CYCLE = 2'd3
  } cfg_idx_e;

  localparam int CFG_DATA_W = 20;

  typedef struct packed {
    logic [6:0]  dev_addr;
    logic [15:0] half_period;
    logic [19:0] ack_timeout;
    logic [19:0] write_cycle;
  } cfg_t;

  localparam logic [6:0]  DEV_ADDR_RST    = 7'd80;
  localparam logic [15:0] HALF_PERIOD_RST = 16'd5;
  localparam logic [19:0] ACK_TIMEOUT_RST = 20'd72000;
  localparam logic [19:0] WRITE_CYCLE_RST = 20'd1000;

  // bus sequencer phases
  typedef enum logic [4:0] {
    PH_IDLE, PH_ST_A, PH_ST_B, PH_TX_A, PH_TX_B, PH_TX_C,
    PH_AK_A, PH_AK_B, PH_AK_W, PH_RX_A, PH_RX_B, PH_RX_C,
    PH_NK_A, PH_NK_B, PH_SP_A, PH_SP_B, PH_WC
  } phase_e;

  // byte of the transfer being sent
  localparam logic [1:0] STEP_DEV  = 2'd0;
  localparam logic [1:0] STEP_AHI  = 2'd1;
  localparam logic [1:0] STEP_ALO  = 2'd2;
  localparam logic [1:0] STEP_LAST = 2'd3;

endpackage

FILE: hdl/i2c_eeprom_byte_access_master_core.sv
// ----------------------------------------------------------------------------
// i2c_eeprom_byte_access_master_core - I2C byte write / random read master
// Throughput one word per cycle unless the result side stalls: the sequencer
// makes one bus step per word, and its result goes to an output register.
// Reset: queue empty, sequencer idle, registers at their default values.
// ----------------------------------------------------------------------------
module i2c_eeprom_byte_access_master_core import i2cebm_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // input words: one time tick or command each
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_item_t              in_data_i,
  // result words: bus levels and status of each tick
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_item_t             out_data_o,
  // register writes
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [1:0]            cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  // Structure:
  //   front  - decodes the kind field into tick / write / read entries
  //   queue  - short FIFO so input and sequencer stall independently
  //   back   - SCL/SDA sequencer, one bus step per word, with an output
  //            register; a result taken in the same cycle does not block
  //            the next word

  cfg_t    cfg_q;
  logic    push, full, q_valid, q_ready;
  q_item_t push_item, q_item;

  // Register writes are always taken; user must issue them only while idle.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dev_addr    <= DEV_ADDR_RST;
      cfg_q.half_period <= HALF_PERIOD_RST;
      cfg_q.ack_timeout <= ACK_TIMEOUT_RST;
      cfg_q.write_cycle <= WRITE_CYCLE_RST;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        REG_DEV_ADDR:    cfg_q.dev_addr    <= cfg_data_i[6:0];
        REG_HALF_PERIOD: cfg_q.half_period <= cfg_data_i[15:0];
        REG_ACK_TIMEOUT: cfg_q.ack_timeout <= cfg_data_i[19:0];
        REG_WRITE_CYCLE: cfg_q.write_cycle <= cfg_data_i[19:0];
        default: begin
          cfg_q <= cfg_q;
        end
      endcase
    end
  end

  i2cebm_front u_front (
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .push_o      (push),
    .push_item_o (push_item),
    .full_i      (full)
  );

  i2cebm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .full_o      (full),
    .valid_o     (q_valid),
    .item_o      (q_item),
    .pop_i       (q_ready)
  );

  // Sequencer: commands seen while a transfer runs act as plain ticks.
  i2cebm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_ready_o   (q_ready),
    .q_item_i    (q_item),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

FILE: hdl/i2cebm_front.sv
// ----------------------------------------------------------------------------
// i2cebm_front
// Input side: takes words and classifies them into tick or command entries.
// ----------------------------------------------------------------------------
module i2cebm_front import i2cebm_pkg::*; (
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_item_t in_data_i,
  output logic     push_o,
  output q_item_t  push_item_o,
  input  logic     full_i
);

  cmd_e cmd;

  // kind three counts as a plain tick
  always_comb begin
    case (in_data_i.kind)
      KIND_WRITE: cmd = CMD_WRITE;
      KIND_READ:  cmd = CMD_READ;
      default:    cmd = CMD_TICK;
    endcase
  end

  assign in_ready_o              = !full_i;
  assign push_o                  = in_valid_i && !full_i;
  assign push_item_o.cmd         = cmd;
  assign push_item_o.mem_address = in_data_i.mem_address;
  assign push_item_o.write_data  = in_data_i.write_data;
  assign push_item_o.sda_in      = in_data_i.sda_in;

endmodule

FILE: hdl/i2cebm_queue.sv
// ----------------------------------------------------------------------------
// i2cebm_queue
// Short FIFO of classified words between front and sequencer.
// ----------------------------------------------------------------------------
`include "i2c_eeprom_byte_access_master_core_assert.svh"

module i2cebm_queue import i2cebm_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  q_item_t push_item_i,
  output logic    full_o,
  output logic    valid_o,
  output q_item_t item_o,
  input  logic    pop_i
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  q_item_t          mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             pop;

  assign full_o  = (cnt_q == CNT_FULL);
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_ptr_q];
  assign pop     = pop_i && valid_o;

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (pop && !push_i) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  `I2CEBM_NEVER(a_cnt_range, cnt_q > CNT_FULL, "queue count past depth")
  `I2CEBM_ASSERT(a_grow, push_i && !pop |=> cnt_q == $past(cnt_q) + CNT_W'(1), "count missed push")
  `I2CEBM_ASSERT(a_shrink, pop && !push_i |=> cnt_q == $past(cnt_q) - CNT_W'(1), "count missed pop")

endmodule

FILE: hdl/i2cebm_back.sv
// ----------------------------------------------------------------------------
// i2cebm_back
// Bus sequencer: one step per queued word, result held in an output register.
// ----------------------------------------------------------------------------
`include "i2c_eeprom_byte_access_master_core_assert.svh"

module i2cebm_back import i2cebm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      q_valid_i,
  output logic      q_ready_o,
  input  q_item_t   q_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  phase_e      phase_q, phase_d, e_phase;
  logic [19:0] tick_q, tick_d, e_tick;
  logic [3:0]  bit_q, bit_d, e_bit;
  logic [7:0]  shift_q, shift_d;
  logic [15:0] addr_q, e_addr;
  logic [7:0]  data_q, e_data;
  logic        rd_q, e_rd;
  logic [19:0] ackw_q, ackw_d, e_ackw;
  logic [1:0]  step_q, step_d, e_step;

  logic        out_valid_q;
  out_item_t   out_q, res;
  logic        step, is_cmd, sda;
  logic [19:0] hp_len, wc_len, ack_lim, tick_inc, ack_inc;
  logic        hp_end, wc_end, ack_end;
  logic [3:0]  bit_inc;

  function automatic logic [7:0] tx_byte(input logic [1:0] stp, input logic [6:0] dev,
                                         input logic [15:0] addr, input logic [7:0] data,
                                         input logic rd);
    logic [7:0] b;
    case (stp)
      STEP_DEV: b = {dev, 1'b0};
      STEP_AHI: b = addr[15:8];
      STEP_ALO: b = addr[7:0];
      default:  b = rd ? {dev, 1'b1} : data;
    endcase
    return b;
  endfunction

  assign q_ready_o = !out_valid_q || out_ready_i;
  assign step      = q_valid_i && q_ready_o;
  assign sda       = q_item_i.sda_in;

  // a command taken while idle starts the transfer in the same step
  always_comb begin
    is_cmd = (phase_q == PH_IDLE) &&
             (q_item_i.cmd == CMD_WRITE || q_item_i.cmd == CMD_READ);
    if (is_cmd) begin
      e_phase = PH_ST_A;
      e_tick  = '0;
      e_bit   = '0;
      e_ackw  = '0;
      e_step  = STEP_DEV;
      e_addr  = q_item_i.mem_address;
      e_data  = q_item_i.write_data;
      e_rd    = (q_item_i.cmd == CMD_READ);
    end else begin
      e_phase = phase_q;
      e_tick  = tick_q;
      e_bit   = bit_q;
      e_ackw  = ackw_q;
      e_step  = step_q;
      e_addr  = addr_q;
      e_data  = data_q;
      e_rd    = rd_q;
    end
  end

  // zero lengths count as one tick
  assign hp_len   = (cfg_i.half_period == '0) ? 20'd1 : {4'd0, cfg_i.half_period};
  assign wc_len   = (cfg_i.write_cycle == '0) ? 20'd1 : cfg_i.write_cycle;
  assign ack_lim  = (cfg_i.ack_timeout == '0) ? 20'd1 : cfg_i.ack_timeout;
  assign tick_inc = e_tick + 20'd1;
  assign ack_inc  = e_ackw + 20'd1;
  assign hp_end   = (tick_inc >= hp_len);
  assign wc_end   = (tick_inc >= wc_len);
  assign ack_end  = (ack_inc >= ack_lim);
  assign bit_inc  = e_bit + 4'd1;

  // next state
  always_comb begin
    phase_d = e_phase;
    tick_d  = hp_end ? '0 : tick_inc;
    bit_d   = e_bit;
    shift_d = shift_q;
    ackw_d  = e_ackw;
    step_d  = e_step;
    case (e_phase)
      PH_IDLE: begin
        tick_d = e_tick;
      end
      PH_ST_A: begin
        if (hp_end) phase_d = PH_ST_B;
      end
      PH_ST_B: begin
        if (hp_end) begin
          shift_d = tx_byte(e_step, cfg_i.dev_addr, e_addr, e_data, e_rd);
          bit_d   = '0;
          phase_d = PH_TX_A;
        end
      end
      PH_TX_A: begin
        if (hp_end) phase_d = PH_TX_B;
      end
      PH_TX_B: begin
        if (hp_end) phase_d = PH_TX_C;
      end
      PH_TX_C: begin
        if (hp_end) begin
          shift_d = {shift_q[6:0], 1'b0};
          bit_d   = bit_inc;
          phase_d = (bit_inc >= 4'd8) ? PH_AK_A : PH_TX_A;
        end
      end
      PH_AK_A: begin
        if (hp_end) phase_d = PH_AK_B;
      end
      PH_AK_B: begin
        if (hp_end) begin
          phase_d = PH_AK_W;
          ackw_d  = '0;
        end
      end
      PH_AK_W: begin
        tick_d = e_tick;
        if (!sda) begin
          ackw_d = '0;
          tick_d = '0;
          if (e_step == STEP_DEV || e_step == STEP_AHI || (e_step == STEP_ALO && !e_rd)) begin
            step_d  = e_step + 2'd1;
            shift_d = tx_byte(e_step + 2'd1, cfg_i.dev_addr, e_addr, e_data, e_rd);
            bit_d   = '0;
            phase_d = PH_TX_A;
          end else if (e_step == STEP_ALO) begin
            step_d  = STEP_LAST;
            phase_d = PH_ST_A;
          end else if (e_rd) begin
            shift_d = '0;
            bit_d   = '0;
            phase_d = PH_RX_A;
          end else begin
            phase_d = PH_SP_A;
          end
        end else begin
          ackw_d = ack_inc;
          if (ack_end) begin
            ackw_d  = '0;
            tick_d  = '0;
            step_d  = STEP_DEV;
            phase_d = PH_ST_A;
          end
        end
      end
      PH_RX_A: begin
        if (hp_end) phase_d = PH_RX_B;
      end
      PH_RX_B: begin
        if (hp_end) begin
          shift_d = {shift_q[6:0], sda};
          phase_d = PH_RX_C;
        end
      end
      PH_RX_C: begin
        if (hp_end) begin
          bit_d   = bit_inc;
          phase_d = (bit_inc >= 4'd8) ? PH_NK_A : PH_RX_A;
        end
      end
      PH_NK_A: begin
        if (hp_end) phase_d = PH_NK_B;
      end
      PH_NK_B: begin
        if (hp_end) phase_d = PH_SP_A;
      end
      PH_SP_A: begin
        if (hp_end) phase_d = PH_SP_B;
      end
      PH_SP_B: begin
        if (hp_end) begin
          phase_d = (e_rd || cfg_i.write_cycle == '0) ? PH_IDLE : PH_WC;
        end
      end
      PH_WC: begin
        tick_d = wc_end ? '0 : tick_inc;
        if (wc_end) phase_d = PH_IDLE;
      end
      default: begin
        phase_d = PH_IDLE;
        tick_d  = '0;
      end
    endcase
  end

  // outputs of this step
  always_comb begin
    res.scl_level   = 1'b1;
    res.sda_release = 1'b1;
    res.busy_res    = (e_phase != PH_IDLE);
    res.done_res    = 1'b0;
    res.read_data   = '0;
    res.retry       = 1'b0;
    case (e_phase)
      PH_ST_B, PH_SP_A: begin
        res.sda_release = 1'b0;
      end
      PH_TX_A, PH_TX_C: begin
        res.scl_level   = 1'b0;
        res.sda_release = shift_q[7];
      end
      PH_TX_B: begin
        res.sda_release = shift_q[7];
      end
      PH_AK_A, PH_RX_A, PH_NK_A: begin
        res.scl_level = 1'b0;
      end
      PH_AK_W: begin
        res.retry = sda && ack_end;
      end
      PH_SP_B: begin
        res.done_res  = hp_end && (e_rd || cfg_i.write_cycle == '0);
        res.read_data = (hp_end && e_rd) ? shift_q : '0;
      end
      PH_WC: begin
        res.done_res = wc_end;
      end
      default: begin
        res.scl_level = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      tick_q      <= '0;
      bit_q       <= '0;
      shift_q     <= '0;
      addr_q      <= '0;
      data_q      <= '0;
      rd_q        <= 1'b0;
      ackw_q      <= '0;
      step_q      <= STEP_DEV;
      out_valid_q <= 1'b0;
    end else begin
      if (step) begin
        phase_q     <= phase_d;
        tick_q      <= tick_d;
        bit_q       <= bit_d;
        shift_q     <= shift_d;
        addr_q      <= e_addr;
        data_q      <= e_data;
        rd_q        <= e_rd;
        ackw_q      <= ackw_d;
        step_q      <= step_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `I2CEBM_ASSERT(a_done_idle, step && res.done_res |=> phase_q == PH_IDLE, "done without idle")
  `I2CEBM_ASSERT(a_retry_start, step && res.retry |=> phase_q == PH_ST_A, "retry did not restart")
  `I2CEBM_NEVER(a_bit_range, bit_q > 4'd8, "bit count past eight")
  `I2CEBM_NEVER(a_done_retry, step && res.done_res && res.retry, "done and retry together")

endmodule

FILE: sim/tb_i2c_eeprom_byte_access_master_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_i2c_eeprom_byte_access_master_core
// Self-checking bench for the I2C EEPROM byte write / random read master.
// Every word sent in is one bus tick. A cycle-exact bus sequencer in the
// bench predicts SCL, SDA and status for each tick, and every result word
// is compared against it field by field. Directed transfers cover the
// register extremes, a missing acknowledge, commands while busy, the
// write-cycle wait and a long receiver hold-off, with random ack delays.
// ----------------------------------------------------------------------------
module tb_i2c_eeprom_byte_access_master_core;
  import i2cebm_pkg::*;

  localparam logic [1:0]  KIND_SPARE  = 2'd3;      // unused kind, acts as a tick
  localparam int          HOLD_CYCLES = 100;       // long receiver hold-off
  localparam int unsigned CYCLE_LIMIT = 3_000_000;

  // --------------------------------------------------------------------------
  // Clock, reset and DUT
  // --------------------------------------------------------------------------
  logic                  clk_i     = 1'b0;
  logic                  rst_ni    = 1'b0;
  logic                  in_valid  = 1'b0;
  in_item_t              in_word   = '0;
  logic                  out_ready = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic [1:0]            cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  in_ready_o;
  logic                  out_valid_o;
  out_item_t             out_data_o;
  logic                  cfg_ready_o;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  i2c_eeprom_byte_access_master_core uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_word),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Bus sequencer copy: registers and state
  // --------------------------------------------------------------------------
  logic [6:0]  dev_addr_r;
  logic [15:0] half_period_r;
  logic [19:0] ack_limit_r;
  logic [19:0] write_wait_r;

  phase_e      bus_phase;
  logic [19:0] tick_cnt;
  logic [3:0]  bits_done;
  logic [7:0]  shreg;
  logic [15:0] addr_hold;
  logic [7:0]  data_hold;
  logic        rd_mode;
  logic [19:0] ack_ticks;
  logic [1:0]  byte_idx;

  out_item_t   bus_levels_q[$];   // predicted levels, oldest first
  int          mismatch_count = 0;
  bit          sender_gaps     = 1'b1;
  bit          receiver_stalls = 1'b1;
  bit          hold_request    = 1'b0;

  // one tick of a timed phase; high when the phase ends
  function automatic logic phase_over(logic [19:0] len);
    logic [19:0] lim;
    lim = (len == '0) ? 20'd1 : len;
    tick_cnt = tick_cnt + 20'd1;
    if (tick_cnt >= lim) begin
      tick_cnt = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // next byte of the transfer into the shifter
  function automatic void load_next_byte();
    case (byte_idx)
      STEP_DEV: shreg = {dev_addr_r, 1'b0};
      STEP_AHI: shreg = addr_hold[15:8];
      STEP_ALO: shreg = addr_hold[7:0];
      default:  shreg = rd_mode ? {dev_addr_r, 1'b1} : data_hold;
    endcase
    bits_done = '0;
    tick_cnt  = '0;
    bus_phase = PH_TX_A;
  endfunction

  // advance the sequencer by one tick and return the bus levels of that tick
  function automatic out_item_t bus_tick(in_item_t w);
    out_item_t   r;
    logic [19:0] hp;
    logic [19:0] lim;
    r             = '0;
    r.scl_level   = 1'b1;
    r.sda_release = 1'b1;
    hp            = {4'd0, half_period_r};

    // a command only starts from idle; the command tick is the first start tick
    if (bus_phase == PH_IDLE && (w.kind == KIND_WRITE || w.kind == KIND_READ)) begin
      addr_hold = w.mem_address;
      data_hold = w.write_data;
      rd_mode   = (w.kind == KIND_READ);
      byte_idx  = STEP_DEV;
      tick_cnt  = '0;
      ack_ticks = '0;
      bits_done = '0;
      bus_phase = PH_ST_A;
    end

    if (bus_phase != PH_IDLE) begin
      r.busy_res = 1'b1;
      case (bus_phase)
        PH_ST_A: begin
          if (phase_over(hp)) bus_phase = PH_ST_B;
        end
        PH_ST_B: begin
          r.sda_release = 1'b0;
          if (phase_over(hp)) load_next_byte();
        end
        PH_TX_A, PH_TX_B, PH_TX_C: begin
          r.sda_release = shreg[7];
          r.scl_level   = (bus_phase == PH_TX_B);
          if (phase_over(hp)) begin
            if (bus_phase == PH_TX_A) bus_phase = PH_TX_B;
            else if (bus_phase == PH_TX_B) bus_phase = PH_TX_C;
            else begin
              shreg     = shreg << 1;
              bits_done = bits_done + 4'd1;
              bus_phase = (bits_done >= 4'd8) ? PH_AK_A : PH_TX_A;
            end
          end
        end
        PH_AK_A: begin
          r.scl_level = 1'b0;
          if (phase_over(hp)) bus_phase = PH_AK_B;
        end
        PH_AK_B: begin
          if (phase_over(hp)) begin
            bus_phase = PH_AK_W;
            ack_ticks = '0;
          end
        end
        PH_AK_W: begin
          // SCL held high; SDA low is the acknowledge
          if (!w.sda_in) begin
            ack_ticks = '0;
            tick_cnt  = '0;
            if (byte_idx < STEP_ALO || (byte_idx == STEP_ALO && !rd_mode)) begin
              byte_idx = byte_idx + 2'd1;
              load_next_byte();
            end else if (byte_idx == STEP_ALO) begin
              byte_idx  = STEP_LAST;   // repeated start before the read device byte
              bus_phase = PH_ST_A;
            end else if (rd_mode) begin
              shreg     = '0;
              bits_done = '0;
              bus_phase = PH_RX_A;
            end else begin
              bus_phase = PH_SP_A;
            end
          end else begin
            lim       = (ack_limit_r == '0) ? 20'd1 : ack_limit_r;
            ack_ticks = ack_ticks + 20'd1;
            if (ack_ticks >= lim) begin
              // no ack in time: whole transfer again from start
              r.retry   = 1'b1;
              ack_ticks = '0;
              tick_cnt  = '0;
              byte_idx  = STEP_DEV;
              bus_phase = PH_ST_A;
            end
          end
        end
        PH_RX_A, PH_RX_B, PH_RX_C: begin
          r.scl_level = (bus_phase != PH_RX_A);
          if (phase_over(hp)) begin
            if (bus_phase == PH_RX_A) bus_phase = PH_RX_B;
            else if (bus_phase == PH_RX_B) begin
              shreg     = {shreg[6:0], w.sda_in};   // sampled at the end of SCL high
              bus_phase = PH_RX_C;
            end else begin
              bits_done = bits_done + 4'd1;
              bus_phase = (bits_done >= 4'd8) ? PH_NK_A : PH_RX_A;
            end
          end
        end
        PH_NK_A: begin
          r.scl_level = 1'b0;
          if (phase_over(hp)) bus_phase = PH_NK_B;
        end
        PH_NK_B: begin
          if (phase_over(hp)) bus_phase = PH_SP_A;
        end
        PH_SP_A: begin
          r.sda_release = 1'b0;
          if (phase_over(hp)) bus_phase = PH_SP_B;
        end
        PH_SP_B: begin
          if (phase_over(hp)) begin
            if (rd_mode || write_wait_r == '0) begin
              r.done_res  = 1'b1;
              r.read_data = rd_mode ? shreg : 8'h00;
              bus_phase   = PH_IDLE;
            end else begin
              bus_phase = PH_WC;
            end
          end
        end
        PH_WC: begin
          if (phase_over(write_wait_r)) begin
            r.done_res = 1'b1;
            bus_phase  = PH_IDLE;
          end
        end
        default: begin
          bus_phase = PH_IDLE;
          tick_cnt  = '0;
        end
      endcase
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Result side: ready with random stalls, long hold-off on request
  // --------------------------------------------------------------------------
  initial begin : result_drain
    int n;
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_request = 1'b0;
        out_ready <= 1'b1;
      end else if (receiver_stalls && $urandom_range(0, 9) == 0) begin
        out_ready <= 1'b0;
        n = $urandom_range(1, 16);
        repeat (n) @(posedge clk_i);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatch_count++;
    end
  endfunction

  // compare each result word with the oldest prediction
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && out_ready) begin
      if (bus_levels_q.size() == 0) begin
        $error("result word with nothing predicted: %0h", out_data_o);
        mismatch_count++;
      end else begin
        want = bus_levels_q.pop_front();
        check_field("scl_level",   8'(want.scl_level),   8'(out_data_o.scl_level));
        check_field("sda_release", 8'(want.sda_release), 8'(out_data_o.sda_release));
        check_field("busy_res",    8'(want.busy_res),    8'(out_data_o.busy_res));
        check_field("done_res",    8'(want.done_res),    8'(out_data_o.done_res));
        check_field("read_data",   want.read_data,       out_data_o.read_data);
        check_field("retry",       8'(want.retry),       8'(out_data_o.retry));
      end
    end
  end

  // hard stop if the run hangs
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("TEST FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Word and register traffic
  // --------------------------------------------------------------------------
  // valid stays up after the handshake; the caller either sends on or settles
  task automatic send_word(input in_item_t w);
    int gap;
    if (sender_gaps && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 16);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_word  <= w;
    in_valid <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    bus_levels_q.push_back(bus_tick(w));
  endtask

  // tick or spare kind with random operands; never starts a transfer
  task automatic send_idle_word();
    in_item_t w;
    w.kind        = $urandom_range(0, 1) ? KIND_SPARE : KIND_TICK;
    w.mem_address = 16'($urandom);
    w.write_data  = 8'($urandom);
    w.sda_in      = 1'($urandom_range(0, 1));
    send_word(w);
  endtask

  // drain all predictions, then give the pipe a few cycles
  task automatic settle_bus();
    in_valid <= 1'b0;
    while (bus_levels_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_register(input cfg_idx_e idx, input logic [19:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      REG_DEV_ADDR:    dev_addr_r    = value[6:0];
      REG_HALF_PERIOD: half_period_r = value[15:0];
      REG_ACK_TIMEOUT: ack_limit_r   = value;
      REG_WRITE_CYCLE: write_wait_r  = value;
      default: ;
    endcase
  endtask

  // writes all four registers; only ever called with the sequencer idle
  task automatic apply_settings(input logic [19:0] dev, input logic [19:0] hp,
                                input logic [19:0] ack, input logic [19:0] wc);
    settle_bus();
    write_register(REG_DEV_ADDR, dev);
    write_register(REG_HALF_PERIOD, hp);
    write_register(REG_ACK_TIMEOUT, ack);
    write_register(REG_WRITE_CYCLE, wc);
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // One full transfer, from the command word until the sequencer is idle.
  // rx_bits: bits the device returns on a read, MSB first.
  // miss_mask: bit n set holds SDA high through the n-th ack window until retry.
  // noisy: random commands thrown in while busy, which must be ignored.
  task automatic run_transfer(input logic [1:0] kind, input logic [15:0] addr,
                              input logic [7:0] data, input logic [7:0] rx_bits,
                              input logic [7:0] miss_mask, input bit noisy);
    in_item_t w;
    int       ack_n;
    int       eff_limit;
    bit       was_ack;
    ack_n         = 0;
    w.kind        = kind;
    w.mem_address = addr;
    w.write_data  = data;
    w.sda_in      = 1'($urandom_range(0, 1));
    send_word(w);
    while (bus_phase != PH_IDLE) begin
      w.kind        = KIND_TICK;
      w.mem_address = 16'($urandom);
      w.write_data  = 8'($urandom);
      w.sda_in      = 1'($urandom_range(0, 1));
      if (noisy && $urandom_range(0, 5) == 0) w.kind = 2'($urandom_range(KIND_WRITE, KIND_SPARE));
      eff_limit = (ack_limit_r == '0) ? 1 : int'(ack_limit_r);
      case (bus_phase)
        PH_AK_W: begin
          if (ack_n < 8 && miss_mask[ack_n]) w.sda_in = 1'b1;
          // short ack delay, kept under the timeout
          else if (int'(ack_ticks) + 1 < eff_limit && $urandom_range(0, 3) == 0)
            w.sda_in = 1'b1;
          else w.sda_in = 1'b0;
        end
        PH_RX_B: w.sda_in = rx_bits[3'd7 - bits_done[2:0]];
        default: ;
      endcase
      was_ack = (bus_phase == PH_AK_W);
      send_word(w);
      if (was_ack && bus_phase != PH_AK_W) ack_n++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // idle words of both idle kinds (tick, spare) at operand extremes: bus stays released
  task automatic test_idle_words();
    in_item_t w;
    w = '{kind: KIND_TICK, mem_address: 16'h0000, write_data: 8'h00, sda_in: 1'b0};
    send_word(w);
    w = '{kind: KIND_TICK, mem_address: 16'hFFFF, write_data: 8'hFF, sda_in: 1'b1};
    send_word(w);
    w = '{kind: KIND_SPARE, mem_address: 16'hFFFF, write_data: 8'hFF, sda_in: 1'b1};
    send_word(w);
    w = '{kind: KIND_SPARE, mem_address: 16'h0000, write_data: 8'h00, sda_in: 1'b0};
    send_word(w);
  endtask

  // zero half period / timeout behave as one tick, zero write cycle skips the
  // wait; data bits above a register's width dropped; commands while busy ignored
  task automatic test_config_extremes();
    apply_settings(20'hFFF80, 20'hF0000, 20'h00000, 20'h00000);
    run_transfer(KIND_WRITE, 16'hA5C3, 8'hA5, 8'h00, 8'h00, 1'b1);
  endtask

  // random read with a missing ack on the device byte, then a clean rerun
  task automatic test_ack_timeout();
    apply_settings(20'h0007F, 20'd1, 20'd2, 20'd3);
    run_transfer(KIND_READ, 16'h7FFE, 8'h00, 8'h96, 8'b0000_0001, 1'b1);
  endtask

  // top of every register range; only idle words, a transfer would be far too long
  task automatic test_high_extremes();
    apply_settings(20'h0007F, 20'h0FFFF, 20'hFFFFF, 20'hFFFFF);
    repeat (8) send_idle_word();
  endtask

  // receiver holds off while words keep coming: the core must fill and stall;
  // runs last with no idling on either side, write-cycle wait included
  task automatic test_output_backpressure();
    apply_settings(20'($urandom_range(0, 127)), 20'd1, 20'd2, 20'd2);
    sender_gaps     = 1'b0;
    receiver_stalls = 1'b0;
    hold_request    = 1'b1;
    run_transfer(KIND_WRITE, 16'($urandom), 8'($urandom), 8'h00, 8'h00, 1'b0);
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    // sequencer copy at its reset values
    dev_addr_r    = DEV_ADDR_RST;
    half_period_r = HALF_PERIOD_RST;
    ack_limit_r   = ACK_TIMEOUT_RST;
    write_wait_r  = WRITE_CYCLE_RST;
    bus_phase     = PH_IDLE;
    tick_cnt      = '0;
    bits_done     = '0;
    shreg         = '0;
    addr_hold     = '0;
    data_hold     = '0;
    rd_mode       = 1'b0;
    ack_ticks     = '0;
    byte_idx      = STEP_DEV;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_idle_words();
    test_config_extremes();
    test_ack_timeout();
    test_high_extremes();
    test_output_backpressure();

    settle_bus();
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0 && bus_levels_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
